@@ src/baro_temp_pressure_compensation_macros.svh @@
// Assertion helpers for the compensation block.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define BTPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication failed");

// Check that the consequent holds in the cycle after the antecedent.
`define BTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

@@ src/btpc_pkg.sv @@
`timescale 1ns / 1ps
package btpc_pkg;

	typedef struct packed {
		logic        cmd;
		logic [23:0] raw_reading;
	} in_beat_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [27:0] temperature_tenths;
		logic signed [31:0] pressure_pa;
		logic               divide_error;
	} out_beat_t;

	localparam logic CMD_TEMP  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	localparam int unsigned REG_AC1_AC2 = 0;
	localparam int unsigned REG_AC3_AC4 = 1;
	localparam int unsigned REG_AC5_AC6 = 2;
	localparam int unsigned REG_B1_B2   = 3;
	localparam int unsigned REG_MC_MD   = 4;
	localparam int unsigned REG_OSS     = 5;

	// Datapath micro-operations.
	typedef enum logic [4:0] {
		OP_T_X1, OP_T_DIV, OP_T_FIN,
		OP_P_B6, OP_P_SQ, OP_P_X1A, OP_P_X2A, OP_P_B3, OP_P_X1B, OP_P_X2B,
		OP_P_X3, OP_P_B4, OP_P_B7, OP_P_DIV, OP_P_DIVFIX, OP_P_PS, OP_P_SQP,
		OP_P_M1, OP_P_M2, OP_P_FIN
	} op_t;

	typedef struct packed {
		logic start;   // load operands and clear accumulators
		logic exec;    // perform op
		op_t  op;
		logic div_go;  // start divider
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_zero;   // divisor of the pending divide is zero
	} status_t;

	function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
		logic signed [31:0] s;
		s = v;
		return 32'(s >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

@@ src/btpc_div.sv @@
`timescale 1ns / 1ps
// Radix-2 restoring divider, 32 bit unsigned, one quotient bit per cycle.
module btpc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
	assign busy = (cnt_q != 6'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule

@@ src/btpc_datapath.sv @@
`timescale 1ns / 1ps
module btpc_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  btpc_pkg::cmd_t       cmd,
	output btpc_pkg::status_t    status,
	input  btpc_pkg::in_beat_t   item,
	input  logic [31:0]          cal_ac1_ac2,
	input  logic [31:0]          cal_ac3_ac4,
	input  logic [31:0]          cal_ac5_ac6,
	input  logic [31:0]          cal_b1_b2,
	input  logic [31:0]          cal_mc_md,
	input  logic [1:0]           oss,
	output btpc_pkg::out_beat_t  result
);
	import btpc_pkg::*;

	logic [31:0] b5_q, raw_q, x1_q, x2_q, x3_q, b6_q, sq_q, b3_q, b4_q, b7_q, p_q;
	logic        neg_q, kind_q;
	logic [1:0]  oss_q;
	logic [31:0] mul_a, mul_b, prod;
	logic [31:0] div_n, div_d, div_qt;
	logic [31:0] den, mc_abs, den_abs, up, t_x2;
	logic        div_busy;

	assign prod = mul_a * mul_b;
	assign den = x1_q + sx16(cal_mc_md[15:0]);
	assign mc_abs = cal_mc_md[31] ? 32'(-sx16(cal_mc_md[31:16])) : {16'd0, cal_mc_md[31:16]};
	assign den_abs = den[31] ? -den : den;
	assign up = 32'(raw_q >> (4'd8 - {2'b0, oss_q}));
	// Signed temperature quotient, truncated toward zero.
	assign t_x2 = neg_q ? -div_qt : div_qt;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_T_X1:  begin
				mul_a = 32'({16'd0, raw_q[15:0]} - {16'd0, cal_ac5_ac6[15:0]});
				mul_b = {16'd0, cal_ac5_ac6[31:16]}; end
			OP_P_SQ:  begin mul_a = b6_q; mul_b = b6_q; end
			OP_P_X1A: begin mul_a = sx16(cal_b1_b2[15:0]); mul_b = sq_q; end
			OP_P_X2A: begin mul_a = sx16(cal_ac1_ac2[15:0]); mul_b = b6_q; end
			OP_P_X1B: begin mul_a = sx16(cal_ac3_ac4[31:16]); mul_b = b6_q; end
			OP_P_X2B: begin mul_a = sx16(cal_b1_b2[31:16]); mul_b = sq_q; end
			OP_P_B4:  begin mul_a = {16'd0, cal_ac3_ac4[15:0]}; mul_b = x3_q + 32'd32768; end
			OP_P_B7:  begin mul_a = up - b3_q; mul_b = 32'd50000 >> oss_q; end
			OP_P_SQP: begin mul_a = asr32(p_q, 8); mul_b = asr32(p_q, 8); end
			OP_P_M1:  begin mul_a = x1_q; mul_b = 32'd3038; end
			OP_P_M2:  begin mul_a = 32'(-32'sd7357); mul_b = p_q; end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		div_n = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
		div_d = b4_q;
		if (kind_q == CMD_TEMP) begin
			div_n = {mc_abs[20:0], 11'd0};
			div_d = den_abs;
		end
	end

	btpc_div u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go),
		.dividend(div_n), .divisor(div_d), .busy(div_busy), .quotient(div_qt)
	);

	assign status.div_busy = div_busy;
	assign status.div_zero = (kind_q == CMD_TEMP) ? (den == 32'd0) : (b4_q == 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b5_q <= '0;
		end else if (cmd.exec && cmd.op == OP_T_FIN && den != 32'd0) begin
			b5_q <= x1_q + t_x2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			raw_q  <= {8'd0, item.raw_reading};
			kind_q <= item.cmd;
			oss_q  <= oss;
			result <= {item.cmd, 28'd0, 32'd0, 1'b0};
		end else if (cmd.exec) begin
			case (cmd.op)
				OP_T_X1:  x1_q <= asr32(prod, 15);
				OP_T_DIV: begin
					neg_q <= cal_mc_md[31] ^ den[31];
				end
				OP_T_FIN: begin
					if (den == 32'd0) begin
						result.divide_error <= 1'b1;
					end else begin
						result.temperature_tenths <=
							28'(asr32(x1_q + t_x2 + 32'd8, 4));
					end
				end
				OP_P_B6:  b6_q <= b5_q - 32'd4000;
				OP_P_SQ:  sq_q <= asr32(prod, 12);
				OP_P_X1A: x1_q <= asr32(prod, 11);
				OP_P_X2A: x2_q <= asr32(prod, 11);
				OP_P_B3:  b3_q <= asr32(((32'(sx16(cal_ac1_ac2[31:16]) << 2) + x1_q + x2_q)
					<< oss_q) + 32'd2, 2);
				OP_P_X1B: x1_q <= asr32(prod, 13);
				OP_P_X2B: x2_q <= asr32(prod, 16);
				OP_P_X3:  x3_q <= asr32(x1_q + x2_q + 32'd2, 2);
				OP_P_B4:  b4_q <= prod >> 15;
				OP_P_B7:  b7_q <= prod;
				OP_P_DIVFIX: p_q <= b7_q[31] ? {div_qt[30:0], 1'b0} : div_qt;
				OP_P_SQP: x1_q <= prod;
				OP_P_M1:  x1_q <= asr32(prod, 16);
				OP_P_M2:  x2_q <= asr32(prod, 16);
				OP_P_FIN: begin
					if (b4_q == 32'd0) begin
						result.divide_error <= 1'b1;
					end else begin
						result.pressure_pa <= p_q + asr32(x1_q + x2_q + 32'd3791, 4);
					end
				end
				default: ;
			endcase
		end
	end
endmodule

@@ src/btpc_ctrl.sv @@
`timescale 1ns / 1ps
module btpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              in_cmd,
	output logic              out_valid,
	input  logic              out_stall,
	output btpc_pkg::cmd_t    cmd,
	input  btpc_pkg::status_t status
);
	import btpc_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_RUN, S_WAITDIV, S_OUT} state_t;
	state_t state_q;
	op_t    op_q;
	logic   busy_q;

	assign in_stall = (state_q != S_IDLE) && !(state_q == S_OUT && !out_stall);

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		cmd.start = !in_stall && in_valid;
		cmd.exec = (state_q == S_RUN);
		cmd.div_go = (state_q == S_RUN) && (op_q == OP_T_DIV || op_q == OP_P_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_T_X1;
			out_valid <= 1'b0;
			busy_q    <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_RUN: begin
					case (op_q)
						OP_T_X1:  op_q <= OP_T_DIV;
						OP_T_DIV: begin
							busy_q <= 1'b1;
							state_q <= status.div_zero ? S_RUN : S_WAITDIV;
							op_q <= OP_T_FIN;
						end
						OP_T_FIN, OP_P_FIN: begin
							state_q <= S_OUT;
							out_valid <= 1'b1;
						end
						OP_P_X3:  op_q <= OP_P_B4;
						OP_P_B7:  op_q <= OP_P_DIV;
						OP_P_DIV: begin
							state_q <= status.div_zero ? S_RUN : S_WAITDIV;
							op_q <= status.div_zero ? OP_P_FIN : OP_P_DIVFIX;
						end
						default:  op_q <= op_t'(op_q + 5'd1);
					endcase
				end
				S_WAITDIV: begin
					busy_q <= 1'b0;
					if (!status.div_busy && !busy_q) begin
						state_q <= S_RUN;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.start) begin
				state_q <= S_RUN;
				op_q <= (in_cmd == CMD_PRESS) ? OP_P_B6 : OP_T_X1;
			end
		end
	end
endmodule

@@ src/baro_temp_pressure_compensation.sv @@
`timescale 1ns / 1ps
// Barometric temperature and pressure compensation.
// Input channel (in_valid/in_stall/in_data): one beat is one raw reading,
// cmd 0 for a 16-bit temperature reading, cmd 1 for a 24-bit pressure readout.
// Output channel (out_valid/out_stall/out_data): one result beat per input beat.
// A temperature beat with a nonzero divisor refreshes the stored B5 that later
// pressure beats use. Calibration words and oversampling are written over the APB
// port; the user must write them only while idle; the block does not enforce it.
// Each result is worked out in multiply steps around the shared radix-2 divider.
// A zero divisor skips the wait for the divider, returns 0 and sets divide_error.
// One item is in flight at a time; the next beat is taken in the cycle its
// predecessor's result beat leaves.
// While the receiver stalls, the result beat holds steady in out_data.
// Reset clears calibration, oversampling and B5 to zero and empties the block.
module baro_temp_pressure_compensation (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  btpc_pkg::in_beat_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output btpc_pkg::out_beat_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import btpc_pkg::*;

	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;
	cmd_t        cmd;
	status_t     status;
	logic        wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// Hold calibration registers; write on the APB access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0; ac34_q <= '0; ac56_q <= '0;
			b12_q <= '0; mcmd_q <= '0; oss_q <= '0;
		end else if (wr) begin
			case (32'(paddr[4:2]))
				REG_AC1_AC2: ac12_q <= pwdata;
				REG_AC3_AC4: ac34_q <= pwdata;
				REG_AC5_AC6: ac56_q <= pwdata;
				REG_B1_B2:   b12_q  <= pwdata;
				REG_MC_MD:   mcmd_q <= pwdata;
				REG_OSS:     oss_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (32'(paddr[4:2]))
			REG_AC1_AC2: prdata = ac12_q;
			REG_AC3_AC4: prdata = ac34_q;
			REG_AC5_AC6: prdata = ac56_q;
			REG_B1_B2:   prdata = b12_q;
			REG_MC_MD:   prdata = mcmd_q;
			REG_OSS:     prdata = {30'd0, oss_q};
			default:     prdata = '0;
		endcase
	end

	btpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_cmd(in_data.cmd), .out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .status(status)
	);

	btpc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .item(in_data),
		.cal_ac1_ac2(ac12_q), .cal_ac3_ac4(ac34_q), .cal_ac5_ac6(ac56_q),
		.cal_b1_b2(b12_q), .cal_mc_md(mcmd_q), .oss(oss_q), .result(out_data)
	);
endmodule

@@ src/btpc_checker.sv @@
`timescale 1ns / 1ps
`include "baro_temp_pressure_compensation_macros.svh"
module btpc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input btpc_pkg::in_beat_t   in_data,
	input logic                 out_valid,
	input logic                 out_stall,
	input btpc_pkg::out_beat_t  out_data
);
	import btpc_pkg::*;

	`BTPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`BTPC_ASSERT_IMP(a_busy_stall, clk, arst_n, out_valid && out_stall, in_stall)
	`BTPC_ASSERT_NEXT(a_no_instant, clk, arst_n, in_valid && !in_stall, !out_valid)
	`BTPC_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && out_data.divide_error,
		out_data.pressure_pa == 32'd0 && out_data.temperature_tenths == 28'd0)
endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
